### src/ssd_pkg.sv
// Shared types, constants and lookup functions for the seven-segment serial driver.
`default_nettype none
package ssd_pkg;

  localparam int unsigned DIGITS_DEF    = 4;
  localparam int unsigned VAL_W         = 14;    // holds 0..9999
  localparam int unsigned BITS_PER_DIG  = 16;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam logic [15:0] RECIP10       = 16'd52429; // floor(x*52429 >> 19) == x/10 below 43699
  localparam int unsigned RECIP_SHIFT   = 19;
  localparam logic [1:0]  POS_ONES      = 2'd3;
  localparam logic [3:0]  BIT_LAST      = 4'd15;

  // one digit handed from the front end to the serializer
  typedef struct packed {
    logic [7:0] seg;
    logic [1:0] pos;
    logic       last;
  } dig_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // largest value that n digits can show
  function automatic int unsigned digit_limit(input int unsigned n);
    int unsigned lim;
    lim = 1;
    for (int i = 0; i < 4; i++) begin
      if (i < n) lim = lim * 10;
    end
    return lim - 1;
  endfunction

  // active-low segment pattern
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  // digit select byte for a display position
  function automatic logic [7:0] sel_of(input logic [1:0] p);
    logic [7:0] s;
    case (p)
      2'd0: s = 8'hF1;
      2'd1: s = 8'hF2;
      2'd2: s = 8'hF4;
      2'd3: s = 8'hF8;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### src/ssd_front.sv
// Front end: takes a value, saturates it and peels off one decimal digit per cycle while the queue has room.
`default_nettype none
module ssd_front #(
  parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [15:0]          in_value,
  input  wire ssd_pkg::q_stat_t     q_stat,
  output logic                      push,
  output ssd_pkg::dig_t             push_dig
);

  localparam logic [ssd_pkg::VAL_W-1:0] LIMIT =
    ssd_pkg::VAL_W'(ssd_pkg::digit_limit(DIGITS));
  localparam logic [1:0] K_LAST = 2'(DIGITS - 1);

  logic                        conv_r, conv_nxt;
  logic [1:0]                  k_r, k_nxt;
  logic [ssd_pkg::VAL_W-1:0]   val_r, val_nxt;

  logic [29:0]                 prod;
  logic [ssd_pkg::VAL_W-1:0]   quo;
  logic [ssd_pkg::VAL_W-1:0]   quo10;
  logic [3:0]                  dig;
  logic                        accept;

  assign busy   = conv_r;
  assign accept = start && !conv_r;

  // divide by ten through the reciprocal, remainder by subtraction
  assign prod  = 30'(val_r) * 30'(ssd_pkg::RECIP10);
  assign quo   = ssd_pkg::VAL_W'(prod >> ssd_pkg::RECIP_SHIFT);
  assign quo10 = ssd_pkg::VAL_W'({quo, 3'b000}) + ssd_pkg::VAL_W'({quo, 1'b0});
  assign dig   = 4'(val_r - quo10);

  assign push          = conv_r && !q_stat.full;
  assign push_dig.seg  = ssd_pkg::seg_of(dig);
  assign push_dig.pos  = ssd_pkg::POS_ONES - k_r;
  assign push_dig.last = (k_r == K_LAST);

  always_comb begin
    conv_nxt = conv_r;
    k_nxt    = k_r;
    val_nxt  = val_r;
    if (accept) begin
      conv_nxt = 1'b1;
      k_nxt    = 2'd0;
      val_nxt  = (in_value > 16'(LIMIT)) ? LIMIT : ssd_pkg::VAL_W'(in_value);
    end else if (push) begin
      val_nxt = quo;
      k_nxt   = k_r + 2'd1;
      if (k_r == K_LAST) conv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= 1'b0;
      k_r    <= 2'd0;
    end else begin
      conv_r <= conv_nxt;
      k_r    <= k_nxt;
    end
    val_r <= val_nxt;
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !accept) else $error("front accepted while converting");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_dig.last) |=> !conv_r) else $error("conversion did not end");
  a_first_digit: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (conv_r && k_r == 2'd0)) else $error("conversion did not start");
`endif

endmodule
`default_nettype wire

### src/ssd_queue.sv
// Small digit queue between the front end and the serializer.
`default_nettype none
module ssd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ssd_pkg::dig_t     push_dig,
  input  wire logic              pop,
  output ssd_pkg::dig_t          pop_dig,
  output ssd_pkg::q_stat_t       q_stat
);

  localparam int unsigned AW = $clog2(ssd_pkg::QUEUE_DEPTH);

  ssd_pkg::dig_t  mem_r [ssd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [AW-1:0]  rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (AW+1)'(ssd_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_dig      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = pop  ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_dig;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue underflow");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + (AW+1)'(1)) else $error("count slip");
`endif

endmodule
`default_nettype wire

### src/ssd_back.sv
// Serializer: shifts each digit out as a 16-bit segment/select word, MSB first.
`default_nettype none
module ssd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ssd_pkg::q_stat_t  q_stat,
  input  wire ssd_pkg::dig_t     pop_dig,
  output logic                   pop,
  output logic                   out_strobe,
  output logic                   out_data_bit,
  output logic [1:0]             out_digit_position,
  output logic [3:0]             out_bit_number,
  output logic                   out_latch_after,
  output logic                   out_last
);

  logic        act_r;
  logic [3:0]  bcnt_r;
  logic [15:0] sh_r;
  logic [1:0]  pos_r;
  logic        last_r;
  logic        at_end;

  assign at_end = (bcnt_r == ssd_pkg::BIT_LAST);
  assign pop    = !q_stat.empty && (!act_r || at_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      bcnt_r <= 4'd0;
    end else if (pop) begin
      act_r  <= 1'b1;
      bcnt_r <= 4'd0;
    end else if (act_r) begin
      act_r  <= !at_end;
      bcnt_r <= bcnt_r + 4'd1;
    end
    if (pop) begin
      sh_r   <= {pop_dig.seg, ssd_pkg::sel_of(pop_dig.pos)};
      pos_r  <= pop_dig.pos;
      last_r <= pop_dig.last;
    end else begin
      sh_r   <= {sh_r[14:0], 1'b0};
    end
  end

  assign out_strobe         = act_r;
  assign out_data_bit       = sh_r[15];
  assign out_digit_position = pos_r;
  assign out_bit_number     = bcnt_r;
  assign out_latch_after    = at_end;
  assign out_last           = at_end && last_r;

`ifndef ASSERT_OFF
  a_bit_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && !at_end) |=> (act_r && bcnt_r == $past(bcnt_r) + 4'd1))
    else $error("bit counter slip");
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (act_r && bcnt_r == 4'd0)) else $error("digit load failed");
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && !at_end) |=> $stable(pos_r)) else $error("position changed mid-digit");
`endif

endmodule
`default_nettype wire

### src/seven_segment_serial_display_driver_unit.sv
// Top level of the seven-segment serial display driver.
`default_nettype none
// A value is taken on a clock edge with start high and busy low. It is
// clamped to the largest number DIGITS digits can show (9999 for four) and
// sent as one refresh frame of 16*DIGITS serial beats, one beat per clock
// with out_strobe high: ones digit first, then tens, hundreds, thousands.
// Each digit is its active-low segment byte then its select byte, MSB first;
// out_latch_after marks the 16th beat of each digit and out_last the final
// beat of the frame. There is no way to hold results off, so the beats of
// a frame leave back to back, and the serial shifter sets the sustained
// rate at which values are taken. The front end splits the value one digit
// per cycle into a four-entry digit queue, stalling while the queue is
// full, and raises busy only while it splits digits or waits on the queue,
// so the next value is usually taken while the previous frame is still
// shifting out. When the serializer is idle, the first beat of a frame
// appears once its digit has passed through the queue and shift register.
module seven_segment_serial_display_driver_unit #(
  parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_value,
  output logic             out_strobe,
  output logic             out_data_bit,
  output logic [1:0]       out_digit_position,
  output logic [3:0]       out_bit_number,
  output logic             out_latch_after,
  output logic             out_last
);

  ssd_pkg::q_stat_t q_stat;
  ssd_pkg::dig_t    push_dig;
  ssd_pkg::dig_t    pop_dig;
  logic             push;
  logic             pop;

  // digit extraction
  ssd_front #(.DIGITS(DIGITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .q_stat   (q_stat),
    .push     (push),
    .push_dig (push_dig)
  );

  // decouples digit extraction from the bit-serial shift of each digit
  ssd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_dig (push_dig),
    .pop      (pop),
    .pop_dig  (pop_dig),
    .q_stat   (q_stat)
  );

  // serial output
  ssd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .pop_dig            (pop_dig),
    .pop                (pop),
    .out_strobe         (out_strobe),
    .out_data_bit       (out_data_bit),
    .out_digit_position (out_digit_position),
    .out_bit_number     (out_bit_number),
    .out_latch_after    (out_latch_after),
    .out_last           (out_last)
  );

endmodule
`default_nettype wire
